/* rtl/set_assoc_cache_tag_controller_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the cache tag controller core RTL
// Same-cycle and next-cycle implications with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SACC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define SACC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/sacc_pkg.sv */
// ----------------------------------------------------------------------------
// sacc_pkg
// Geometry, payload types and address helpers of the cache tag controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sacc_pkg;

  localparam int SETS       = 64;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 32;

  localparam int ADDR_W     = 32;
  localparam int OFF_BITS   = $clog2(LINE_BYTES);
  localparam int IDX_BITS   = $clog2(SETS);
  localparam int HIGH_SHIFT = OFF_BITS + IDX_BITS;
  localparam int TAG_BITS   = ADDR_W - HIGH_SHIFT;
  localparam int SET_W      = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W     = WAY_W;

  localparam logic [ADDR_W-1:0] IDX_MASK = ADDR_W'((64'd1 << IDX_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << OFF_BITS) - 64'd1);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic              writeback_valid;
    logic [ADDR_W-1:0] writeback_address;
    logic              fetch_valid;
    logic [ADDR_W-1:0] fetch_address;
  } out_item_t;

  // One set: tag, valid bit, dirty bit and LRU rank of every way.
  typedef struct packed {
    logic [WAYS-1:0][TAG_BITS-1:0] tag;
    logic [WAYS-1:0]               valid;
    logic [WAYS-1:0]               dirty;
    logic [WAYS-1:0][RANK_W-1:0]   rank;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef logic [SET_W-1:0]    set_idx_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [WAYS-1:0]     way_mask_t;

  // Set index, wrapped into range when SETS is not a power of two.
  function automatic set_idx_t set_of(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] raw;
    raw = (addr >> OFF_BITS) & IDX_MASK;
    if (raw >= ADDR_W'(SETS)) begin
      raw = raw - ADDR_W'(SETS);
    end
    return SET_W'(raw);
  endfunction

  function automatic tag_t tag_of(input logic [ADDR_W-1:0] addr);
    return TAG_BITS'(addr >> HIGH_SHIFT);
  endfunction

  // Row contents of a set that has never been written.
  function automatic row_t reset_row();
    row_t row;
    row = '0;
    for (int w = 0; w < WAYS; w++) begin
      row.rank[w] = RANK_W'(w);
    end
    return row;
  endfunction

endpackage

`default_nettype wire

/* rtl/set_assoc_cache_tag_controller_core.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_core
// Write-back, write-allocate, LRU tag controller of a set-associative cache.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_req (command, byte address) and raise start; the access
//   transfers at each rising edge where start is high and busy is low. busy
//   stays low, so one access can transfer every cycle.
//   Output: out_valid marks one cycle in which out_res carries hit, the
//   writeback request of a dirty victim and the fetch request of a miss.
//   The receiver takes it at the end of that cycle and cannot stall.
//   Pipeline: the tag RAM read of the set is registered at the transfer
//   edge, the compare, victim choice and LRU update run in the next cycle,
//   and out_valid rises at the edge after the transfer. One result per
//   cycle. A same-set access in the next cycle sees the updated set through
//   a forwarding register.
//   Reset: clears the per-set written flags; no clearing pass runs, so
//   accesses may start right after reset. A set never written reads as
//   invalid and clean, with each way ranked by its number.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_cache_tag_controller_core_macros.svh"

module set_assoc_cache_tag_controller_core import sacc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_req,
  output logic          out_valid,
  output out_item_t     out_res
);

  logic                  accept;
  set_idx_t              in_set;

  logic                  s1_vld_r, s1_vld_nxt;
  in_item_t              s1_req_r, s1_req_nxt;
  set_idx_t              s1_set;

  logic                  fwd_r, fwd_nxt;
  row_t                  fwd_row_r, fwd_row_nxt;

  logic [SETS-1:0]       row_wr_r, row_wr_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_res_r, out_res_nxt;

  logic [ROW_W-1:0]      ram_rdata;
  row_t                  row_cur;
  row_t                  row_new;
  out_item_t             lk_res;
  logic [(2**RANK_W)-1:0] rank_seen;

  // The pipe takes an access every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign in_set = set_of(in_req.address);
  assign s1_set = set_of(s1_req_r.address);

  sacc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .ADDR_W(SET_W)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  (s1_vld_r),
    .wr_addr(s1_set),
    .wr_data(row_new),
    .rd_en  (accept),
    .rd_addr(in_set),
    .rd_data(ram_rdata)
  );

  // Forwarded row wins over the RAM, which missed the write of the prior access.
  always_comb begin
    if (fwd_r) begin
      row_cur = fwd_row_r;
    end else if (row_wr_r[s1_set]) begin
      row_cur = row_t'(ram_rdata);
    end else begin
      row_cur = reset_row();
    end
  end

  sacc_lookup u_lookup (
    .command(s1_req_r.command),
    .address(s1_req_r.address),
    .row_i  (row_cur),
    .row_o  (row_new),
    .res_o  (lk_res)
  );

  always_comb begin
    s1_vld_nxt    = accept;
    s1_req_nxt    = accept ? in_req : s1_req_r;
    fwd_nxt       = accept && s1_vld_r && (in_set == s1_set);
    fwd_row_nxt   = row_new;
    out_valid_nxt = s1_vld_r;
    out_res_nxt   = lk_res;
    row_wr_nxt    = row_wr_r;
    if (s1_vld_r) begin
      row_wr_nxt[s1_set] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      row_wr_r    <= '0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
      row_wr_r    <= row_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r  <= s1_req_nxt;
    fwd_row_r <= fwd_row_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Ranks written back must still cover every position once.
  always_comb begin
    rank_seen = '0;
    for (int w = 0; w < WAYS; w++) begin
      rank_seen[row_new.rank[w]] = 1'b1;
    end
  end

  `SACC_ASSERT_NOW(a_rank_perm, clk, rst_n, s1_vld_r, $countones(rank_seen) == WAYS)
  `SACC_ASSERT_NOW(a_hit_xor_fetch, clk, rst_n, out_valid, out_res.hit != out_res.fetch_valid)
  `SACC_ASSERT_NOW(a_wb_on_miss, clk, rst_n, out_valid && out_res.writeback_valid, out_res.fetch_valid)
  `SACC_ASSERT_NEXT(a_latency, clk, rst_n, s1_vld_r, out_valid)
  `SACC_ASSERT_NEXT(a_set_filled, clk, rst_n, s1_vld_r, row_wr_r[$past(s1_set)])

endmodule

`default_nettype wire

/* rtl/sacc_ram.sv */
// ----------------------------------------------------------------------------
// sacc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sacc_lookup.sv */
// ----------------------------------------------------------------------------
// sacc_lookup
// Tag compare, victim choice, LRU update and result build for one access.
// ----------------------------------------------------------------------------
`default_nettype none

module sacc_lookup import sacc_pkg::*; (
  input  wire logic              command,
  input  wire logic [ADDR_W-1:0] address,
  input  wire row_t              row_i,
  output row_t                   row_o,
  output out_item_t              res_o
);

  set_idx_t          set_idx;
  tag_t              tag;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic              inv_found;
  logic [WAY_W-1:0]  inv_way;
  logic              lru_found;
  logic [WAY_W-1:0]  lru_way;
  logic [WAY_W-1:0]  victim;
  logic [WAY_W-1:0]  way;
  logic [RANK_W-1:0] old_rank;
  logic              wb;

  assign set_idx = set_of(address);
  assign tag     = tag_of(address);

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_found = 1'b0;
    lru_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && row_i.valid[w] && (row_i.tag[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!inv_found && !row_i.valid[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
      if (!lru_found && (row_i.rank[w] == RANK_W'(WAYS - 1))) begin
        lru_found = 1'b1;
        lru_way   = WAY_W'(w);
      end
    end
    victim = inv_found ? inv_way : lru_way;
    way    = hit ? hit_way : victim;
  end

  // Promote the touched way to most recent; age the ones that were younger.
  always_comb begin
    old_rank = row_i.rank[way];
    row_o    = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (row_i.rank[w] < old_rank) begin
        row_o.rank[w] = row_i.rank[w] + RANK_W'(1);
      end
    end
    row_o.rank[way] = '0;
    if (hit) begin
      if (command == CMD_WRITE) begin
        row_o.dirty[way] = 1'b1;
      end
    end else begin
      row_o.tag[way]   = tag;
      row_o.dirty[way] = (command == CMD_WRITE);
    end
    row_o.valid[way] = 1'b1;
  end

  always_comb begin
    wb    = !hit && row_i.valid[victim] && row_i.dirty[victim];
    res_o = '0;
    res_o.hit = hit;
    if (!hit) begin
      res_o.fetch_valid   = 1'b1;
      res_o.fetch_address = address & ~OFF_MASK;
      if (wb) begin
        res_o.writeback_valid   = 1'b1;
        res_o.writeback_address = (ADDR_W'(row_i.tag[victim]) << HIGH_SHIFT)
                                | (ADDR_W'(set_idx) << OFF_BITS);
      end
    end
  end

endmodule

`default_nettype wire

/* verif/set_assoc_cache_tag_controller_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller_core_tb
// Self-checking bench for the LRU write-back tag controller. It sends directed
// and random accesses and predicts hit, writeback and fetch for each access.
// It checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------

module set_assoc_cache_tag_controller_core_tb;
  import sacc_pkg::*;

  localparam int  CLK_HALF    = 5;
  localparam int  RAND_ITEMS  = 1300;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  TAIL_CYCLES = 10;
  localparam int  POOL_SIZE   = 8;

  typedef logic [RANK_W-1:0] rank_t;

  typedef struct {
    in_item_t req;
    bit       drain_first;  // hold until every predicted result has arrived
  } access_slot_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_req;
  logic      out_valid;
  out_item_t out_res;

  // Predicted cache directory.
  tag_t  dir_tag   [SETS][WAYS];
  logic  dir_valid [SETS][WAYS];
  logic  dir_dirty [SETS][WAYS];
  rank_t dir_rank  [SETS][WAYS];

  access_slot_t access_q[$];
  out_item_t    predicted_q[$];
  tag_t         tag_pool[POOL_SIZE];

  int unsigned accepted_cnt;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  set_assoc_cache_tag_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Make a way most recently used; ranks above it in recency age by one.
  function automatic void touch_way(int unsigned set_i, int unsigned way);
    rank_t old_rank;
    old_rank = dir_rank[set_i][way];
    for (int w = 0; w < WAYS; w++) begin
      if (dir_rank[set_i][w] < old_rank) begin
        dir_rank[set_i][w] = dir_rank[set_i][w] + 1'b1;
      end
    end
    dir_rank[set_i][way] = '0;
  endfunction

  function automatic out_item_t cache_lookup(in_item_t req);
    out_item_t         res;
    logic [ADDR_W-1:0] idx_raw;
    int unsigned       set_i;
    tag_t              tag;
    int                hit_way;
    int                victim;
    res     = '0;
    idx_raw = (req.address >> OFF_BITS) & IDX_MASK;
    set_i   = idx_raw % SETS;
    tag     = tag_t'(req.address >> HIGH_SHIFT);
    hit_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_way < 0 && dir_valid[set_i][w] && dir_tag[set_i][w] == tag) begin
        hit_way = w;
      end
    end
    if (hit_way >= 0) begin
      if (req.command == CMD_WRITE) begin
        dir_dirty[set_i][hit_way] = 1'b1;
      end
      touch_way(set_i, hit_way);
      res.hit = 1'b1;
      return res;
    end
    // Invalid way first, else the least recently used one.
    victim = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (victim < 0 && !dir_valid[set_i][w]) begin
        victim = w;
      end
    end
    if (victim < 0) begin
      for (int w = 0; w < WAYS; w++) begin
        if (victim < 0 && dir_rank[set_i][w] == rank_t'(WAYS - 1)) begin
          victim = w;
        end
      end
    end
    if (dir_valid[set_i][victim] && dir_dirty[set_i][victim]) begin
      res.writeback_valid   = 1'b1;
      res.writeback_address = (ADDR_W'(dir_tag[set_i][victim]) << HIGH_SHIFT) |
                              (ADDR_W'(set_i) << OFF_BITS);
    end
    dir_tag[set_i][victim]   = tag;
    dir_valid[set_i][victim] = 1'b1;
    dir_dirty[set_i][victim] = (req.command == CMD_WRITE);
    touch_way(set_i, victim);
    res.fetch_valid   = 1'b1;
    res.fetch_address = req.address & ~OFF_MASK;
    return res;
  endfunction

  function automatic void check_field(string name, logic [ADDR_W-1:0] exp_val,
                                      logic [ADDR_W-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endfunction

  function automatic void queue_access(logic cmd, logic [ADDR_W-1:0] addr, bit drain);
    access_slot_t slot;
    slot.req.command = cmd;
    slot.req.address = addr;
    slot.drain_first = drain;
    access_q = {access_q, slot};
  endfunction

  // Mostly accesses from a small pool of tags, half to sets 0 to 3, so that hits,
  // dirty evictions and LRU reordering happen often.
  function automatic logic [ADDR_W-1:0] pick_address(logic [ADDR_W-1:0] last_addr);
    int unsigned       kind;
    logic [ADDR_W-1:0] set_part;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      return $urandom;
    end
    if (kind < 30) begin
      return last_addr ^ ADDR_W'($urandom_range(0, LINE_BYTES - 1));
    end
    if ($urandom_range(0, 1) == 0) begin
      set_part = ADDR_W'($urandom_range(0, 3));
    end else begin
      set_part = ADDR_W'($urandom_range(0, SETS - 1));
    end
    return (ADDR_W'(tag_pool[$urandom_range(0, POOL_SIZE - 1)]) << HIGH_SHIFT) |
           (set_part << OFF_BITS) | ADDR_W'($urandom_range(0, LINE_BYTES - 1));
  endfunction

  // Driver: present the next access unless idling or waiting for a drain.
  always @(negedge clk) begin
    if (!rst_n || access_q.size() == 0) begin
      start <= 1'b0;
    end else if (access_q[0].drain_first && predicted_q.size() != 0) begin
      start <= 1'b0;
    end else if (!(accepted_cnt >= 500 && accepted_cnt < 800) &&
                 $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
    end else begin
      start  <= 1'b1;
      in_req <= access_q[0].req;
    end
  end

  // Monitor: check result strobes, then predict each accepted transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (predicted_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result expected none actual %0h", $time, out_res);
        end else begin
          check_field("hit", ADDR_W'(predicted_q[0].hit), ADDR_W'(out_res.hit));
          check_field("writeback_valid", ADDR_W'(predicted_q[0].writeback_valid),
                      ADDR_W'(out_res.writeback_valid));
          check_field("writeback_address", predicted_q[0].writeback_address,
                      out_res.writeback_address);
          check_field("fetch_valid", ADDR_W'(predicted_q[0].fetch_valid),
                      ADDR_W'(out_res.fetch_valid));
          check_field("fetch_address", predicted_q[0].fetch_address,
                      out_res.fetch_address);
          void'(predicted_q.pop_front());
        end
      end
      if (start && !busy) begin
        predicted_q = {predicted_q, cache_lookup(in_req)};
        void'(access_q.pop_front());
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] addr;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    accepted_cnt = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        dir_tag[s][w]   = '0;
        dir_valid[s][w] = 1'b0;
        dir_dirty[s][w] = 1'b0;
        dir_rank[s][w]  = rank_t'(w);
      end
    end
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      tag_pool[i] = tag_t'($urandom);
    end

    // Fill set 0, then evict dirty and clean ways in LRU order.
    queue_access(CMD_READ,  32'h0000_0000, 1'b0);  // miss into an empty set
    queue_access(CMD_READ,  32'h0000_0000, 1'b0);  // repeated read hits
    queue_access(CMD_WRITE, 32'h0000_001F, 1'b0);  // write hit marks dirty
    queue_access(CMD_WRITE, 32'h0000_0800, 1'b0);
    queue_access(CMD_READ,  32'h0000_1000, 1'b0);
    queue_access(CMD_WRITE, 32'hFFFF_F800, 1'b0);  // largest tag, set 0
    queue_access(CMD_READ,  32'h0000_2800, 1'b0);  // dirty victim
    queue_access(CMD_READ,  32'h0000_3000, 1'b0);  // dirty victim
    queue_access(CMD_READ,  32'h0000_3800, 1'b0);  // clean victim
    queue_access(CMD_READ,  32'hFFFF_F81F, 1'b0);  // hit on the largest tag
    queue_access(CMD_WRITE, 32'hFFFF_FFFF, 1'b0);  // highest set and tag
    queue_access(CMD_READ,  32'hFFFF_FFE0, 1'b0);
    queue_access(CMD_WRITE, 32'hAAAA_AAAA, 1'b0);
    queue_access(CMD_READ,  32'h5555_5555, 1'b0);
    queue_access(CMD_WRITE, 32'h0000_0000, 1'b0);
    queue_access(CMD_READ,  32'h0000_4000, 1'b0);  // evicts the clean LRU way 1

    addr = 32'h0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      addr = pick_address(addr);
      queue_access(logic'($urandom_range(0, 1)), addr, (i == 0) || (i == 650));
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (access_q.size() == 0 && predicted_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && predicted_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
